// ===== rtl/core/vtp_pkg.sv =====
package vtp_pkg;

  localparam int TagW   = 8;
  localparam int CoordW = 16;
  localparam int ProdW  = 32;  // Q7.8 x Q5.10 product
  localparam int SumW   = 34;  // four products summed
  localparam int DivW   = 34;  // divisor |tw| and partial remainder
  localparam int NumW   = 48;  // dividend
  localparam int QuotW  = 15;  // quotient bits, one per divider stage
  localparam int ResW   = 13;
  localparam int HalfW  = 12;
  localparam int DepthW = 16;

  typedef enum logic [2:0] {
    RegRow0   = 3'd0,
    RegRow1   = 3'd1,
    RegRow2   = 3'd2,
    RegRow3   = 3'd3,
    RegWidth  = 3'd4,
    RegHeight = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic w_zero;
    logic in_x;
    logic in_y;
    logic neg_z;
    logic sat_z;
  } vtp_flags_t;

endpackage

// ===== rtl/core/vertex_transform_project.sv =====
// Vertex transform: 4x4 matrix times homogeneous vertex, perspective divide,
// viewport mapping.
// Input channel: in_valid_i with vertex_tag_i and pos_x/y/z/w_i (Q7.8); a
// word is taken at an edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o with out_tag_o, screen_x/y_o, depth_o (Q3.12)
// and w_zero_o; the word moves when out_valid_o is high and out_stall_i low.
// Config: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; rows 0..3
// of the matrix, then screen width and height. Indices 6 and 7 are dropped.
// Write config only while the pipe is empty.
// Throughput: one vertex per cycle while the output word is not held. The pipe
// has 2 multiply stages, 2 setup stages, 15 restoring divider stages (one quotient
// bit each) and the output register.
// Stall: when the output word is held the whole pipe freezes and in_stall_o
// rises in the same cycle; bubbles ahead of the output still advance only
// together with it, nothing is lost or repeated.
// Reset: valid bits clear, matrix clears to zero, resolution goes to 320x240.
module vertex_transform_project import vtp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [63:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [TagW-1:0]          vertex_tag_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic signed [CoordW-1:0] pos_w_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [TagW-1:0]          out_tag_o,
  output logic [ResW-1:0]          screen_x_o,
  output logic [ResW-1:0]          screen_y_o,
  output logic signed [DepthW-1:0] depth_o,
  output logic                     w_zero_o
);

  logic [3:0][63:0]  row_q;
  logic [ResW-1:0]   width_q, height_q;
  logic              en;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      width_q  <= ResW'(320);
      height_q <= ResW'(240);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRow0:   row_q[0] <= cfg_data_i;
        RegRow1:   row_q[1] <= cfg_data_i;
        RegRow2:   row_q[2] <= cfg_data_i;
        RegRow3:   row_q[3] <= cfg_data_i;
        RegWidth:  width_q  <= cfg_data_i[ResW-1:0];
        RegHeight: height_q <= cfg_data_i[ResW-1:0];
        default: ;
      endcase
    end
  end

  // advance the whole pipe unless the output word is held
  logic out_valid_q;
  assign en         = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~en;

  logic signed [CoordW-1:0] pos [4];
  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;
  assign pos[3] = pos_w_i;

  logic                   xf_valid;
  logic [TagW-1:0]        xf_tag;
  logic signed [SumW-1:0] xf_t [4];

  vtp_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .tag_i   (vertex_tag_i),
    .pos_i   (pos),
    .row_i   (row_q),
    .valid_o (xf_valid),
    .tag_o   (xf_tag),
    .t_o     (xf_t)
  );

  logic            pp_valid;
  logic [TagW-1:0] pp_tag;
  vtp_flags_t      pp_flags;
  logic [NumW-1:0] pp_n [3];
  logic [DivW-1:0] pp_d;

  // half resolution by integer halving
  vtp_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (xf_valid),
    .tag_i    (xf_tag),
    .t_i      (xf_t),
    .half_x_i (width_q[ResW-1:1]),
    .half_y_i (height_q[ResW-1:1]),
    .valid_o  (pp_valid),
    .tag_o    (pp_tag),
    .flags_o  (pp_flags),
    .n_o      (pp_n),
    .d_o      (pp_d)
  );

  logic             dv_valid;
  logic [TagW-1:0]  dv_tag;
  vtp_flags_t       dv_flags;
  logic [QuotW-1:0] dv_q [3];

  vtp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pp_valid),
    .tag_i   (pp_tag),
    .flags_i (pp_flags),
    .n_i     (pp_n),
    .d_i     (pp_d),
    .valid_o (dv_valid),
    .tag_o   (dv_tag),
    .flags_o (dv_flags),
    .q_o     (dv_q)
  );

  // final selection: range clip, depth sign and saturation, zero w
  logic [ResW-1:0]   sx_d, sy_d, sx_q, sy_q;
  logic [DepthW-1:0] dep_d, dep_q;
  logic [TagW-1:0]   tag_q;
  logic              wz_q;

  always_comb begin
    sx_d = dv_flags.in_x ? dv_q[0][ResW-1:0] : '0;
    sy_d = dv_flags.in_y ? dv_q[1][ResW-1:0] : '0;
    if (dv_flags.sat_z) begin
      dep_d = dv_flags.neg_z ? 16'h8000 : 16'h7FFF;
    end else if (dv_flags.neg_z) begin
      dep_d = 16'd0 - {1'b0, dv_q[2]};
    end else begin
      dep_d = {1'b0, dv_q[2]};
    end
    if (dv_flags.w_zero) begin
      sx_d  = '0;
      sy_d  = '0;
      dep_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      dep_q <= dep_d;
      tag_q <= dv_tag;
      wz_q  <= dv_flags.w_zero;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tag_o   = tag_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign depth_o     = dep_q;
  assign w_zero_o    = wz_q;

`ifndef SYNTHESIS
  a_zero_w_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && w_zero_o |-> screen_x_o == '0 && screen_y_o == '0 && depth_o == '0)
    else $error("zero w result carries nonzero fields");

  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow held output");

  a_x_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> screen_x_o <= width_q && screen_y_o <= height_q)
    else $error("pixel beyond resolution");
`endif

endmodule

// ===== rtl/core/vtp_xform.sv =====
module vtp_xform import vtp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [TagW-1:0]          tag_i,
  input  logic signed [CoordW-1:0] pos_i [4],
  input  logic [3:0][63:0]         row_i,
  output logic                     valid_o,
  output logic [TagW-1:0]          tag_o,
  output logic signed [SumW-1:0]   t_o [4]
);

  logic signed [ProdW-1:0] prod_d [4][4];
  logic signed [ProdW-1:0] prod_q [4][4];
  logic signed [SumW-1:0]  t_d [4];
  logic signed [SumW-1:0]  t_q [4];
  logic [TagW-1:0]         tag1_q, tag2_q;
  logic                    v1_q, v2_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_d[r][c] = ProdW'(pos_i[c] * $signed(row_i[r][16*c +: 16]));
      end
      t_d[r] = SumW'(prod_q[r][0]) + SumW'(prod_q[r][1])
             + SumW'(prod_q[r][2]) + SumW'(prod_q[r][3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      t_q    <= t_d;
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  assign valid_o = v2_q;
  assign tag_o   = tag2_q;
  assign t_o     = t_q;

endmodule

// ===== rtl/core/vtp_prep.sv =====
module vtp_prep import vtp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [TagW-1:0]        tag_i,
  input  logic signed [SumW-1:0] t_i [4],
  input  logic [HalfW-1:0]       half_x_i,
  input  logic [HalfW-1:0]       half_y_i,
  output logic                   valid_o,
  output logic [TagW-1:0]        tag_o,
  output vtp_flags_t             flags_o,
  output logic [NumW-1:0]        n_o [3],
  output logic [DivW-1:0]        d_o
);

  logic signed [SumW:0] w_s, aw_s, ax_s, ay_s, tz_s, az_s;
  logic signed [SumW+1:0] sx_s, sy_s;
  logic wneg;
  vtp_flags_t flags_d, flags1_q, flags2_q;
  logic [SumW:0]   sx_q, sy_q;
  logic [DivW-1:0] az_q, aw_q, aw2_q;
  logic [NumW-1:0] n_q [3];
  logic [TagW-1:0] tag1_q, tag2_q;
  logic            v1_q, v2_q;

  // normalize signs so the divisor is not negative
  always_comb begin
    wneg = t_i[3] < 0;
    w_s  = (SumW+1)'(t_i[3]);
    aw_s = wneg ? -w_s : w_s;
    ax_s = wneg ? -(SumW+1)'(t_i[0]) : (SumW+1)'(t_i[0]);
    ay_s = wneg ? -(SumW+1)'(t_i[1]) : (SumW+1)'(t_i[1]);
    tz_s = (SumW+1)'(t_i[2]);
    az_s = (t_i[2] < 0) ? -tz_s : tz_s;
    sx_s = (SumW+2)'(ax_s) + (SumW+2)'(aw_s);
    sy_s = (SumW+2)'(ay_s) + (SumW+2)'(aw_s);
    flags_d.w_zero = (t_i[3] == '0);
    flags_d.in_x   = (ax_s <= aw_s) && (ax_s >= -aw_s);
    flags_d.in_y   = (ay_s <= aw_s) && (ay_s >= -aw_s);
    flags_d.neg_z  = (t_i[2] < 0) != wneg;
    flags_d.sat_z  = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q     <= sx_s[SumW:0];
      sy_q     <= sy_s[SumW:0];
      az_q     <= az_s[DivW-1:0];
      aw_q     <= aw_s[DivW-1:0];
      flags1_q <= flags_d;
      tag1_q   <= tag_i;
      n_q[0]   <= NumW'(sx_q * half_x_i);
      n_q[1]   <= NumW'(sy_q * half_y_i);
      n_q[2]   <= NumW'({az_q, 12'b0});
      aw2_q    <= aw_q;
      tag2_q   <= tag1_q;
      flags2_q <= '{w_zero: flags1_q.w_zero, in_x: flags1_q.in_x, in_y: flags1_q.in_y,
                    neg_z: flags1_q.neg_z,
                    sat_z: ({3'b0, az_q} >= {aw_q, 3'b0})};
    end
  end

  assign valid_o = v2_q;
  assign tag_o   = tag2_q;
  assign flags_o = flags2_q;
  assign n_o     = n_q;
  assign d_o     = aw2_q;

endmodule

// ===== rtl/core/vtp_div.sv =====
module vtp_div import vtp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [TagW-1:0]  tag_i,
  input  vtp_flags_t       flags_i,
  input  logic [NumW-1:0]  n_i [3],
  input  logic [DivW-1:0]  d_i,
  output logic             valid_o,
  output logic [TagW-1:0]  tag_o,
  output vtp_flags_t       flags_o,
  output logic [QuotW-1:0] q_o [3]
);

  // one restoring step per stage, three lanes sharing a divisor
  logic [DivW-1:0]  rem_s  [QuotW+1][3];
  logic [QuotW-1:0] bits_s [QuotW+1][3];
  logic [DivW-1:0]  d_s    [QuotW+1];
  logic [TagW-1:0]  tag_s  [QuotW+1];
  vtp_flags_t       flags_s[QuotW+1];
  logic             v_s    [QuotW+1];

  for (genvar l = 0; l < 3; l++) begin : g_in
    assign rem_s[0][l]  = DivW'(n_i[l][NumW-1:QuotW]);
    assign bits_s[0][l] = n_i[l][QuotW-1:0];
  end
  assign d_s[0]     = d_i;
  assign tag_s[0]   = tag_i;
  assign flags_s[0] = flags_i;
  assign v_s[0]     = valid_i;

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    logic [DivW:0]    trial [3];
    logic             ge    [3];
    logic [DivW-1:0]  rem_d [3];
    logic [QuotW-1:0] bits_d[3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l]  = {rem_s[k][l], bits_s[k][l][QuotW-1]};
        ge[l]     = trial[l] >= {1'b0, d_s[k]};
        rem_d[l]  = ge[l] ? DivW'(trial[l] - {1'b0, d_s[k]}) : trial[l][DivW-1:0];
        bits_d[l] = {bits_s[k][l][QuotW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]   <= rem_d;
        bits_s[k+1]  <= bits_d;
        d_s[k+1]     <= d_s[k];
        tag_s[k+1]   <= tag_s[k];
        flags_s[k+1] <= flags_s[k];
      end
    end
  end

  assign valid_o = v_s[QuotW];
  assign tag_o   = tag_s[QuotW];
  assign flags_o = flags_s[QuotW];
  assign q_o     = bits_s[QuotW];

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import vtp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register indices past the end of the list; writes there are dropped.
  localparam logic [2:0] RegSpare0 = 3'd6;
  localparam logic [2:0] RegSpare1 = 3'd7;
  localparam logic [15:0] One = 16'h0400;  // 1.0 in Q5.10
  localparam int DrainCycles = 30;         // a little more than the pipe depth

  typedef struct {
    logic [TagW-1:0]          tag;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] w;
  } vertex_t;

  typedef struct {
    logic [TagW-1:0]          tag;
    logic [ResW-1:0]          sx;
    logic [ResW-1:0]          sy;
    logic signed [DepthW-1:0] depth;
    logic                     wz;
  } pixel_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [2:0]               cfg_index_i = '0;
  logic [63:0]              cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [TagW-1:0]          vertex_tag_i = '0;
  logic signed [CoordW-1:0] pos_x_i = '0;
  logic signed [CoordW-1:0] pos_y_i = '0;
  logic signed [CoordW-1:0] pos_z_i = '0;
  logic signed [CoordW-1:0] pos_w_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [TagW-1:0]          out_tag_o;
  logic [ResW-1:0]          screen_x_o;
  logic [ResW-1:0]          screen_y_o;
  logic signed [DepthW-1:0] depth_o;
  logic                     w_zero_o;

  vertex_transform_project u_top (.*);

  always #2 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic [63:0]     mat_rows [4];
  logic [ResW-1:0] res_w;
  logic [ResW-1:0] res_h;

  pixel_t pending_pixels [$];
  int     errors = 0;
  int     idle_in = 0;    // sender idle percentage
  int     idle_out = 0;   // receiver stall percentage
  int     hold_cycles = 0;
  int     tag_cnt = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [ResW-1:0] map_to_pixel(longint t, longint w,
                                                   logic [ResW-1:0] res);
    longint half;
    longint num;
    half = longint'(res >> 1);
    if (w < 0) begin
      t = -t;
      w = -w;
    end
    if (t > w || t < -w) return '0;
    num = t * half + w * half;
    return ResW'(num / w);
  endfunction

  function automatic logic [DepthW-1:0] depth_q312(longint z, longint w);
    logic   neg;
    longint mag;
    neg = (z < 0) != (w < 0);
    mag = ((z < 0 ? -z : z) * 4096) / (w < 0 ? -w : w);
    if (neg) return (mag >= 32768) ? 16'h8000 : DepthW'(-mag);
    return (mag > 32767) ? 16'h7fff : DepthW'(mag);
  endfunction

  function automatic pixel_t project_vertex(vertex_t v);
    longint comp [4];
    longint tr [4];
    pixel_t p;
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    comp[3] = v.w;
    for (int r = 0; r < 4; r++) begin
      tr[r] = 0;
      for (int c = 0; c < 4; c++)
        tr[r] += comp[c] * longint'($signed(mat_rows[r][16*c +: 16]));
    end
    p.tag = v.tag;
    if (tr[3] == 0) begin
      p.sx = '0;
      p.sy = '0;
      p.depth = '0;
      p.wz = 1'b1;
    end else begin
      p.sx = map_to_pixel(tr[0], tr[3], res_w);
      p.sy = map_to_pixel(tr[1], tr[3], res_h);
      p.depth = depth_q312(tr[2], tr[3]);
      p.wz = 1'b0;
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < 3'd4) mat_rows[idx] = data;
    else if (idx == RegWidth) res_w = data[ResW-1:0];
    else if (idx == RegHeight) res_h = data[ResW-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                            logic [63:0] r3);
    write_reg(RegRow0, r0);
    write_reg(RegRow1, r1);
    write_reg(RegRow2, r2);
    write_reg(RegRow3, r3);
  endtask

  // Offer one word; returns at the edge that accepts it.
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic signed [15:0] w);
    vertex_t v;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_in) begin
      in_valid_i = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_in);
    end
    v.tag = TagW'(tag_cnt);
    v.x = x;
    v.y = y;
    v.z = z;
    v.w = w;
    tag_cnt = ($urandom_range(9) == 0) ? $urandom : tag_cnt + 1;
    vertex_tag_i = v.tag;
    pos_x_i = x;
    pos_y_i = y;
    pos_z_i = z;
    pos_w_i = w;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_pixels.push_back(project_vertex(v));
  endtask

  // Drop valid, then wait out every expected word and the pipe depth.
  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a long hold-off while hold_cycles runs.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < idle_out);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    pixel_t exp_p;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected word tag %0d", out_tag_o));
      end else begin
        exp_p = pending_pixels.pop_front();
        if (out_tag_o !== exp_p.tag)
          report_mismatch($sformatf("tag %0d, want %0d", out_tag_o, exp_p.tag));
        if (screen_x_o !== exp_p.sx)
          report_mismatch($sformatf("tag %0d screen_x %0d, want %0d",
                                    exp_p.tag, screen_x_o, exp_p.sx));
        if (screen_y_o !== exp_p.sy)
          report_mismatch($sformatf("tag %0d screen_y %0d, want %0d",
                                    exp_p.tag, screen_y_o, exp_p.sy));
        if (depth_o !== exp_p.depth)
          report_mismatch($sformatf("tag %0d depth %0d, want %0d",
                                    exp_p.tag, depth_o, exp_p.depth));
        if (w_zero_o !== exp_p.wz)
          report_mismatch($sformatf("tag %0d w_zero %0b, want %0b",
                                    exp_p.tag, w_zero_o, exp_p.wz));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] jitter(int base, int spread);
    return 16'(base + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic logic [ResW-1:0] pick_res();
    case ($urandom_range(7))
      0: return 13'd2;
      1: return 13'd4096;
      2: return 13'd3;
      3: return ResW'($urandom_range(1));
      default: return ResW'($urandom_range(4096, 2));
    endcase
  endfunction

  task automatic random_config;
    logic [63:0] r [4];
    case ($urandom_range(9))
      0: begin  // anything at all
        for (int i = 0; i < 4; i++) r[i] = {$urandom, $urandom};
      end
      1: begin  // w taken from z: a plain perspective projection
        for (int i = 0; i < 3; i++)
          for (int c = 0; c < 4; c++)
            r[i][16*c +: 16] = jitter((c == i) ? 1024 : 0, 64);
        r[3] = {jitter(0, 4), jitter(1024, 64), jitter(0, 4), jitter(0, 4)};
      end
      default: begin  // near identity, keeps most points on screen
        for (int i = 0; i < 4; i++)
          for (int c = 0; c < 4; c++)
            r[i][16*c +: 16] = jitter((c == i) ? 1024 : 0, (c == i) ? 128 : 48);
      end
    endcase
    set_matrix(r[0], r[1], r[2], r[3]);
    // upper data bits beyond the 13-bit register are ignored
    write_reg(RegWidth, {$urandom, 19'($urandom), pick_res()});
    write_reg(RegHeight, {$urandom, 19'($urandom), pick_res()});
    if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? RegSpare0 : RegSpare1,
                                          {$urandom, $urandom});
  endtask

  task automatic random_vertex;
    int aw;
    int lim;
    logic signed [15:0] w;
    if ($urandom_range(9) < 2) begin  // raw noise over the full range
      send_vertex(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      aw = $urandom_range(32767, 64);
      w = $urandom_range(1) ? 16'(aw) : 16'(-aw);
      lim = aw + aw / 8;  // reach a little past the edges
      if (lim > 32767) lim = 32767;
      send_vertex(16'(int'($urandom_range(2 * lim)) - lim),
                  16'(int'($urandom_range(2 * lim)) - lim),
                  16'(int'($urandom_range(2 * lim)) - lim), w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values;
    // zero matrix after reset: every vertex has zero w
    send_vertex(16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100);
    send_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    drain();
  endtask

  task automatic test_identity_edges;
    set_matrix({48'h0, One}, {32'h0, One, 16'h0}, {16'h0, One, 32'h0},
               {One, 48'h0});
    write_reg(RegWidth, 64'd4096);
    write_reg(RegHeight, 64'd2);
    send_vertex(16'sh0100, -16'sh0100, 16'sh0000, 16'sh0100);  // on the edges
    send_vertex(-16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100);
    send_vertex(16'sh0101, 16'sh0000, 16'sh0000, 16'sh0100);   // just outside
    send_vertex(16'sh0080, 16'sh0040, -16'sh0080, -16'sh0100); // negative w
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_vertex(16'sh1234, 16'sh4321, 16'sh0100, 16'sh0000);   // zero w
    send_vertex(16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0001);   // depth saturates up
    send_vertex(16'sh0000, 16'sh0000, 16'sh8000, 16'sh0001);   // and down
    send_vertex(16'sh0000, 16'sh0000, -16'sh0800, 16'sh0100);  // exactly -8.0
    send_vertex(16'sh0001, -16'sh0001, 16'sh0001, 16'sh7fff);
    drain();
    // resolutions of 0 and 1 collapse everything to column 0
    write_reg(RegWidth, 64'd0);
    write_reg(RegHeight, 64'hffff_ffff_ffff_e001);
    write_reg(RegSpare0, 64'hdead_beef_dead_beef);
    write_reg(RegSpare1, 64'h0);
    send_vertex(16'sh0100, 16'sh0100, 16'sh0000, 16'sh0100);
    send_vertex(-16'sh0080, 16'sh0080, 16'sh0000, 16'sh0100);
    drain();
    // largest coefficients on every entry
    set_matrix(64'h7fff_8000_7fff_8000, 64'h8000_8000_8000_8000,
               64'h7fff_7fff_7fff_7fff, 64'h8000_7fff_8000_7fff);
    write_reg(RegWidth, 64'd4096);
    write_reg(RegHeight, 64'd4096);
    send_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    drain();
  endtask

  task automatic test_random_stream;
    for (int chunk = 0; chunk < 12; chunk++) begin
      // receiver-heavy stalling, then sender-heavy idling, then none
      if (chunk < 4) begin
        idle_in = 24;
        idle_out = 51;
      end else if (chunk < 8) begin
        idle_in = 51;
        idle_out = 24;
      end else begin
        idle_in = 0;
        idle_out = 0;
      end
      random_config();
      if (chunk == 9) hold_cycles = 300;  // fill the pipe against a held output
      for (int n = 0; n < 50; n++) random_vertex();
      drain();
    end
  endtask

  initial begin
    mat_rows = '{default: '0};
    res_w = 13'd320;
    res_h = 13'd240;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_values();
    test_identity_edges();
    test_random_stream();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

endmodule
